>>> design/folp_pkg.sv
// Package for the first-order lag low-pass filter.
// Fixed-point widths, register indexes, reset values, coefficient constants and shared types.
// No dependencies; every other design file uses it by scoped names.
package folp_pkg;

    // Fixed-point formats
    localparam int SAMPLE_BITS = 16;                       // raw sample width
    localparam int FRAC_BITS   = 16;                       // fraction bits of the state
    localparam int COEFF_BITS  = 16;                       // Q0.COEFF_BITS coefficient
    localparam int VAL_W       = SAMPLE_BITS + FRAC_BITS;  // filter state width
    localparam int OUT_W       = 32;                       // filtered_value field width

    // Configuration port
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER_HZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CORN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER   = 3'd5;

    localparam logic [CFG_W-1:0] RST_CORNER_HZ = 20'd0;
    localparam logic [CFG_W-1:0] RST_PERIOD_US = 20'd0;
    localparam logic [CFG_W-1:0] RST_MIN_CORN  = 20'd1;
    localparam logic [CFG_W-1:0] RST_MAX_CORN  = 20'd10000;
    localparam logic [CFG_W-1:0] RST_MIN_PER   = 20'd1;
    localparam logic [CFG_W-1:0] RST_MAX_PER   = 20'd1000000;

    // Coefficient arithmetic: k = pi*p / (1e6 + pi*p), pi and 1e6 in Q20
    localparam int PROD_W = 2 * CFG_W;        // corner * period
    localparam int PI_W   = 22;
    localparam int MEGA_W = 40;
    localparam int NUM_W  = 62;               // pi*p and the divisor fit here
    localparam logic [PI_W-1:0]   PI_Q20   = 22'd3294199;
    localparam logic [MEGA_W-1:0] MEGA_Q20 = 40'd1048576000000;

    // Status of the coefficient unit
    typedef struct packed {
        logic                  busy;
        logic [COEFF_BITS-1:0] coeff;
    } t_coeff_status;

endpackage

>>> design/folp_in_if.sv
// Sample channel of the lag filter: valid/ready with one raw sample per beat.
// Depends on folp_pkg for the sample width.
interface folp_in_if;
    logic                             valid;
    logic                             ready;
    logic [folp_pkg::SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> design/folp_out_if.sv
// Result channel of the lag filter: valid/ready with one filter result per beat.
// Depends on folp_pkg for the output width.
interface folp_out_if;
    logic                       valid;
    logic                       ready;
    logic [folp_pkg::OUT_W-1:0] filtered_value;
    logic                       applied_ok;
    logic                       filter_configured;

    modport source (output valid, output filtered_value, output applied_ok,
                    output filter_configured, input ready);
    modport sink   (input valid, input filtered_value, input applied_ok,
                    input filter_configured, output ready);
endinterface

>>> design/folp_coeff.sv
// Coefficient unit: three multiply steps then a restoring divider, one bit a cycle.
// Depends on folp_pkg.
module folp_coeff (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_cfg_ok,
    input  logic [folp_pkg::CFG_W-1:0]   i_corner,
    input  logic [folp_pkg::CFG_W-1:0]   i_period,
    output folp_pkg::t_coeff_status      o_status
);
    localparam int HALF   = folp_pkg::PROD_W / 2;
    localparam int PP_W   = HALF + folp_pkg::PI_W;
    localparam int CNT_W  = $clog2(folp_pkg::COEFF_BITS);
    localparam int NUM_W  = folp_pkg::NUM_W;
    localparam int CB     = folp_pkg::COEFF_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_P, S_MUL_LO, S_MUL_HI, S_DEN, S_DIV
    } t_state;

    t_state                      r_state;
    logic [folp_pkg::PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]            r_num;
    logic [NUM_W-1:0]            r_den;
    logic [NUM_W-1:0]            r_rem;
    logic [CB-1:0]               r_quot;
    logic [CB-1:0]               r_coeff;
    logic [CNT_W-1:0]            r_cnt;

    logic [folp_pkg::PROD_W-1:0] w_p;
    logic [PP_W-1:0]             w_pp;
    logic [NUM_W:0]              w_shift;
    logic [NUM_W:0]              w_diff;
    logic                        w_ge;
    logic [NUM_W-1:0]            n_rem;

    // corner * period, then one half of that product times pi per cycle
    assign w_p  = folp_pkg::PROD_W'(i_corner) * folp_pkg::PROD_W'(i_period);
    assign w_pp = (r_state == S_MUL_LO)
                ? PP_W'(r_prod[HALF-1:0]) * PP_W'(folp_pkg::PI_Q20)
                : PP_W'(r_prod[folp_pkg::PROD_W-1:HALF]) * PP_W'(folp_pkg::PI_Q20);

    // one restoring step
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign n_rem   = w_ge ? w_diff[NUM_W-1:0] : w_shift[NUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_coeff <= '0;
        end else if (i_start) begin
            r_state <= S_MUL_P;
            r_coeff <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_state <= S_IDLE;
                end
                S_MUL_P: begin
                    // invalid configuration leaves the coefficient at zero
                    if (i_cfg_ok) begin
                        r_prod  <= w_p;
                        r_state <= S_MUL_LO;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL_LO: begin
                    r_num   <= NUM_W'(w_pp);
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_num   <= r_num + (NUM_W'(w_pp) << HALF);
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den   <= r_num + NUM_W'(folp_pkg::MEGA_Q20);
                    r_rem   <= r_num;
                    r_quot  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quot <= {r_quot[CB-2:0], w_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CB - 1)) begin
                        r_coeff <= {r_quot[CB-2:0], w_ge};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_status.busy  = (r_state != S_IDLE);
    assign o_status.coeff = r_coeff;

endmodule

>>> design/first_order_lag_lowpass.sv
// First-order lag low-pass filter over a stream of unsigned converter samples.
// Top level; depends on folp_pkg, folp_in_if, folp_out_if and folp_coeff.
//
// One sample per clock cycle while the coefficient unit is idle and the sink takes
// results; an accepted sample passes an input register, then the multiply-add
// with the stored state into the result register. The input register takes the
// next sample in the same cycle it hands its beat on to the result register; a
// stalled sink holds both registers. Every write to an in-range register restarts
// the filter and recomputes the coefficient; the coefficient unit (three multiply
// steps, a divisor set-up and one quotient bit a cycle) holds the sample channel
// off after the write until it is done, or only through its first multiply step
// when the new setting is out of bounds. While the configuration is out of bounds
// the sample is passed through with applied_ok low.
module first_order_lag_lowpass (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    folp_in_if.sink                        i_adc,
    folp_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [folp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [folp_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int VAL_W  = folp_pkg::VAL_W;
    localparam int CB     = folp_pkg::COEFF_BITS;
    localparam int MP_W   = VAL_W + CB;
    localparam int QS_W   = VAL_W + 2;
    localparam int Y_W    = VAL_W + 3;
    localparam int OUT_W  = folp_pkg::OUT_W;
    localparam int SB     = folp_pkg::SAMPLE_BITS;

    // configuration registers
    logic [folp_pkg::CFG_W-1:0] r_corner, r_period, r_min_c, r_max_c, r_min_p, r_max_p;
    logic                       w_cfg_hit;
    logic                       w_cfg_ok;

    // stages and filter state
    logic             r_in_valid;
    logic [SB-1:0]    r_sample;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_fv;
    logic             r_ok;
    logic             r_cfgd;
    logic [VAL_W-1:0] r_prev;
    logic [CB-1:0]    r_rem;
    logic             r_restart;

    logic [VAL_W-1:0] n_prev;
    logic [CB-1:0]    n_rem;
    logic             n_restart;
    logic [OUT_W-1:0] n_fv;
    logic             n_ok;

    folp_pkg::t_coeff_status w_coeff;

    logic w_in_acc;
    logic w_fire;

    // datapath
    logic [VAL_W-1:0]        w_x;
    logic signed [VAL_W:0]   w_d;
    logic                    w_neg;
    logic [VAL_W-1:0]        w_mag;
    logic [MP_W-1:0]         w_prod;
    logic [VAL_W-1:0]        w_q;
    logic [CB-1:0]           w_f;
    logic [QS_W-1:0]         w_qpos;
    logic [QS_W-1:0]         w_qs;
    logic [CB-1:0]           w_r;
    logic [CB:0]             w_sum;
    logic [Y_W-1:0]          w_y;
    logic                    w_ovf;
    logic                    w_keep;

    // register writes; indexes beyond the list are ignored
    assign w_cfg_hit = i_cfg_we
                    && (i_cfg_idx < folp_pkg::CFG_IDX_W'(folp_pkg::NUM_REGS));

    assign w_cfg_ok = (r_corner != '0) && (r_corner >= r_min_c) && (r_corner <= r_max_c)
                   && (r_period >= r_min_p) && (r_period <= r_max_p);

    folp_coeff u_coeff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cfg_hit),
        .i_cfg_ok (w_cfg_ok),
        .i_corner (r_corner),
        .i_period (r_period),
        .o_status (w_coeff)
    );

    // handshakes: result register drains while the next beat is taken
    assign w_fire      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_adc.ready = !w_coeff.busy && (!r_in_valid || w_fire);
    assign w_in_acc    = i_adc.valid && i_adc.ready;

    // step: y = prev + rem + k*(x - prev), floor at every rounding
    assign w_x    = VAL_W'(r_sample) << folp_pkg::FRAC_BITS;
    assign w_d    = $signed({1'b0, w_x}) - $signed({1'b0, r_prev});
    assign w_neg  = w_d[VAL_W];
    assign w_mag  = w_neg ? VAL_W'(-w_d) : VAL_W'(w_d);
    assign w_prod = MP_W'(w_mag) * MP_W'(w_coeff.coeff);
    assign w_q    = w_prod[MP_W-1:CB];
    assign w_f    = w_prod[CB-1:0];
    assign w_qpos = QS_W'(w_q);
    assign w_qs   = w_neg ? (QS_W'(0) - w_qpos - QS_W'(|w_f)) : w_qpos;
    assign w_r    = w_neg ? (CB'(0) - w_f) : w_f;
    assign w_sum  = {1'b0, r_rem} + {1'b0, w_r};
    assign w_y    = Y_W'(r_prev) + {w_qs[QS_W-1], w_qs} + Y_W'(w_sum[CB]);
    assign w_ovf  = |w_y[Y_W-1:VAL_W];
    assign w_keep = (w_y[VAL_W-1:0] == r_prev) && (w_x != w_y[VAL_W-1:0]);

    // next state and result for the beat in the input register
    always_comb begin
        n_prev    = r_prev;
        n_rem     = r_rem;
        n_restart = r_restart;
        n_fv      = OUT_W'(r_sample);
        n_ok      = 1'b0;
        if (!w_cfg_ok) begin
            n_ok = 1'b0;
        end else if (r_restart) begin
            // seed from the sample and pass it through
            n_prev    = w_x;
            n_rem     = '0;
            n_restart = 1'b0;
            n_ok      = 1'b1;
        end else if (w_ovf) begin
            n_rem     = '0;
            n_restart = 1'b1;
        end else begin
            n_prev = w_y[VAL_W-1:0];
            n_rem  = w_keep ? w_sum[CB-1:0] : '0;
            n_fv   = OUT_W'(w_y[VAL_W-1:0]);
            n_ok   = 1'b1;
        end
    end

    // control, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_rem       <= '0;
            r_restart   <= 1'b1;
            r_corner    <= folp_pkg::RST_CORNER_HZ;
            r_period    <= folp_pkg::RST_PERIOD_US;
            r_min_c     <= folp_pkg::RST_MIN_CORN;
            r_max_c     <= folp_pkg::RST_MAX_CORN;
            r_min_p     <= folp_pkg::RST_MIN_PER;
            r_max_p     <= folp_pkg::RST_MAX_PER;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    folp_pkg::REG_CORNER_HZ: r_corner <= i_cfg_data;
                    folp_pkg::REG_PERIOD_US: r_period <= i_cfg_data;
                    folp_pkg::REG_MIN_CORN:  r_min_c  <= i_cfg_data;
                    folp_pkg::REG_MAX_CORN:  r_max_c  <= i_cfg_data;
                    folp_pkg::REG_MIN_PER:   r_min_p  <= i_cfg_data;
                    folp_pkg::REG_MAX_PER:   r_max_p  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // a register write restarts the filter
            if (w_cfg_hit) begin
                r_rem     <= '0;
                r_restart <= 1'b1;
            end else if (w_fire) begin
                r_prev    <= n_prev;
                r_rem     <= n_rem;
                r_restart <= n_restart;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= i_adc.adc_sample;
        end
        if (w_fire) begin
            r_fv   <= n_fv;
            r_ok   <= n_ok;
            r_cfgd <= w_cfg_ok;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.filtered_value    = r_fv;
    assign o_res.applied_ok        = r_ok;
    assign o_res.filter_configured = r_cfgd;

    // checks
    a_unconf_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.filter_configured |-> !o_res.applied_ok)
        else $error("result flagged ok while unconfigured");

    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> !i_adc.ready)
        else $error("sample channel open while coefficient is recomputed");

    a_restart_no_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_restart |-> (r_rem == '0))
        else $error("remainder kept across a restart");

    a_invalid_zero_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_coeff.busy && !w_cfg_ok |-> (w_coeff.coeff == '0))
        else $error("nonzero coefficient with invalid configuration");

endmodule
